// ===== src/mcct_pkg.sv =====
package mcct_pkg;

    // Velocity difference width (two signed Q7.8 values subtracted).
    localparam int VW = 17;
    // Width of A = U^2 + W^2.
    localparam int AW = 33;
    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 4;
    // Reset value of the radius register (1.0 in Q8.8).
    localparam logic [15:0] RADIUS_RESET = 16'd256;
    // Configuration address width and register index (paddr[2]).
    localparam int PADDR_W = 3;
    localparam logic IDX_RADIUS = 1'b0;
    // Saturation limits of the Q15.16 time.
    localparam logic [31:0] TIME_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] TIME_NEG_MAG = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_MISS,
        KIND_ZERO,
        KIND_SOLVE
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  b_neg;
    } t_ctl;

    function automatic int f_frac(input int p);
        return (p > 8) ? p : 8;
    endfunction

    function automatic int f_s(input int p);
        return 24 - f_frac(p);
    endfunction

    function automatic int f_psh(input int p);
        return f_frac(p) - p;
    endfunction

    function automatic int f_rsh(input int p);
        return f_frac(p) - 8;
    endfunction

    function automatic int f_xw(input int p);
        return 25 + f_psh(p);
    endfunction

    function automatic int f_bw(input int p);
        return f_xw(p) + VW;
    endfunction

    function automatic int f_mw(input int p);
        return f_bw(p) - 1;
    endfunction

    function automatic int f_cw(input int p);
        return 2 * f_xw(p) + 1;
    endfunction

    function automatic int f_cpw(input int p);
        return 2 * f_xw(p) - 1;
    endfunction

    function automatic int f_dw(input int p);
        return AW + f_cpw(p);
    endfunction

    function automatic int f_rtw(input int p);
        return (f_dw(p) + 2 * f_s(p) + 1) / 2;
    endfunction

    function automatic int f_nw(input int p);
        return f_mw(p) + f_s(p);
    endfunction

endpackage

// ===== src/mcct_front.sv =====
module mcct_front import mcct_pkg::*; #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [23:0]                i_first_pos_x,
    input  logic signed [23:0]                i_first_pos_y,
    input  logic signed [23:0]                i_second_pos_x,
    input  logic signed [23:0]                i_second_pos_y,
    input  logic signed [15:0]                i_first_vel_x,
    input  logic signed [15:0]                i_first_vel_y,
    input  logic signed [15:0]                i_second_vel_x,
    input  logic signed [15:0]                i_second_vel_y,
    input  logic [15:0]                       i_radius,
    input  logic                              i_q_full,
    output logic                              o_push,
    output t_ctl                              o_ctl,
    output logic [f_mw(POS_FRAC_BITS)-1:0]    o_babs,
    output logic [AW-1:0]                     o_a,
    output logic [f_dw(POS_FRAC_BITS)-1:0]    o_d
);

    localparam int PSH = f_psh(POS_FRAC_BITS);
    localparam int RSH = f_rsh(POS_FRAC_BITS);
    localparam int XW  = f_xw(POS_FRAC_BITS);
    localparam int BW  = f_bw(POS_FRAC_BITS);
    localparam int MW  = f_mw(POS_FRAC_BITS);
    localparam int CW  = f_cw(POS_FRAC_BITS);
    localparam int CPW = f_cpw(POS_FRAC_BITS);
    localparam int DW  = f_dw(POS_FRAC_BITS);
    localparam int RW  = 16 + RSH;
    localparam int L   = (MW + 1) / 2;
    localparam int CL  = (CPW + 1) / 2;

    logic       w_en;
    logic [7:1] r_v;

    // Stage 1: differences.
    logic signed [XW-1:0] r1_x, r1_y;
    logic signed [VW-1:0] r1_u, r1_w;
    logic [RW-1:0]        r1_r;
    // Stage 2: products.
    logic signed [2*VW-1:0] r2_uu, r2_ww;
    logic signed [BW-1:0]   r2_xu, r2_yw;
    logic signed [2*XW-1:0] r2_xx, r2_yy;
    logic [2*RW-1:0]        r2_rr;
    // Stage 3: quadratic coefficients.
    logic [AW-1:0]        r3_a;
    logic signed [BW-1:0] r3_b;
    logic signed [CW-1:0] r3_c;
    // Stage 4: classification.
    t_ctl           r4_ctl;
    logic [MW-1:0]  r4_babs;
    logic [AW-1:0]  r4_a;
    logic [CPW-1:0] r4_cp;
    // Stage 5: partial products.
    t_ctl                    r5_ctl;
    logic [MW-1:0]           r5_babs;
    logic [AW-1:0]           r5_a;
    logic [2*L-1:0]          r5_ll;
    logic [MW-1:0]           r5_lh;
    logic [2*(MW-L)-1:0]     r5_hh;
    logic [AW+CL-1:0]        r5_acl;
    logic [AW+CPW-CL-1:0]    r5_ach;
    // Stage 6: B^2 and A*C.
    t_ctl          r6_ctl;
    logic [MW-1:0] r6_babs;
    logic [AW-1:0] r6_a;
    logic [DW-1:0] r6_bb, r6_ac;
    // Stage 7: discriminant.
    t_ctl          r7_ctl;
    logic [MW-1:0] r7_babs;
    logic [AW-1:0] r7_a;
    logic [DW-1:0] r7_d;

    logic signed [XW-1:0] w_dx, w_dy;
    logic signed [VW-1:0] w_du, w_dw;
    logic                 w_neg, w_cpos;
    logic [MW-1:0]        w_babs;
    t_kind                w_kind;
    logic [DW:0]          w_diff;
    t_ctl                 w_ctl7;

    // The whole front holds only when its last item cannot enter the queue.
    assign w_en       = !(i_q_full && r_v[7]);
    assign o_in_stall = !w_en;
    assign o_push     = r_v[7] && !i_q_full;
    assign o_ctl      = r7_ctl;
    assign o_babs     = r7_babs;
    assign o_a        = r7_a;
    assign o_d        = r7_d;

    assign w_dx = (XW'(i_first_pos_x) - XW'(i_second_pos_x)) <<< PSH;
    assign w_dy = (XW'(i_first_pos_y) - XW'(i_second_pos_y)) <<< PSH;
    assign w_du = VW'(i_first_vel_x) - VW'(i_second_vel_x);
    assign w_dw = VW'(i_first_vel_y) - VW'(i_second_vel_y);

    always_comb begin
        w_neg  = r3_b[BW-1];
        w_babs = w_neg ? MW'(-r3_b) : MW'(r3_b);
        w_cpos = !r3_c[CW-1] && (r3_c != '0);
        if (r3_a == '0) begin
            w_kind = w_cpos ? KIND_MISS : KIND_ZERO;
        end else if (!w_cpos) begin
            w_kind = KIND_ZERO;
        end else begin
            w_kind = KIND_SOLVE;
        end
    end

    always_comb begin
        w_diff = {1'b0, r6_bb} - {1'b0, r6_ac};
        w_ctl7 = r6_ctl;
        // A negative discriminant means the paths never come that close.
        if (r6_ctl.kind == KIND_SOLVE && w_diff[DW]) begin
            w_ctl7.kind = KIND_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[6:1], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x <= w_dx;
            r1_y <= w_dy;
            r1_u <= w_du;
            r1_w <= w_dw;
            r1_r <= RW'(i_radius) << RSH;

            r2_uu <= r1_u * r1_u;
            r2_ww <= r1_w * r1_w;
            r2_xu <= r1_x * r1_u;
            r2_yw <= r1_y * r1_w;
            r2_xx <= r1_x * r1_x;
            r2_yy <= r1_y * r1_y;
            r2_rr <= r1_r * r1_r;

            r3_a <= AW'(unsigned'(r2_uu)) + AW'(unsigned'(r2_ww));
            r3_b <= r2_xu + r2_yw;
            r3_c <= CW'(r2_xx) + CW'(r2_yy) - CW'(signed'({1'b0, r2_rr}));

            r4_ctl.kind  <= w_kind;
            r4_ctl.b_neg <= w_neg;
            r4_babs      <= w_babs;
            r4_a         <= r3_a;
            r4_cp        <= r3_c[CPW-1:0];

            r5_ctl  <= r4_ctl;
            r5_babs <= r4_babs;
            r5_a    <= r4_a;
            r5_ll   <= r4_babs[L-1:0] * r4_babs[L-1:0];
            r5_lh   <= MW'(r4_babs[L-1:0] * r4_babs[MW-1:L]);
            r5_hh   <= r4_babs[MW-1:L] * r4_babs[MW-1:L];
            r5_acl  <= r4_a * r4_cp[CL-1:0];
            r5_ach  <= r4_a * r4_cp[CPW-1:CL];

            r6_ctl  <= r5_ctl;
            r6_babs <= r5_babs;
            r6_a    <= r5_a;
            r6_bb   <= (DW'(r5_hh) << (2 * L)) + (DW'(r5_lh) << (L + 1)) + DW'(r5_ll);
            r6_ac   <= (DW'(r5_ach) << CL) + DW'(r5_acl);

            r7_ctl  <= w_ctl7;
            r7_babs <= r6_babs;
            r7_a    <= r6_a;
            r7_d    <= w_diff[DW-1:0];
        end
    end

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[7] && i_q_full) |=> r_v[7])
        else $error("front dropped an item blocked by a full queue");

endmodule

// ===== src/mcct_fifo.sv =====
module mcct_fifo import mcct_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== src/mcct_back.sv =====
module mcct_back import mcct_pkg::*; #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  t_ctl                           i_ctl,
    input  logic [f_mw(POS_FRAC_BITS)-1:0] i_babs,
    input  logic [AW-1:0]                  i_a,
    input  logic [f_dw(POS_FRAC_BITS)-1:0] i_d,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic signed [31:0]             o_hit_time
);

    localparam int S   = f_s(POS_FRAC_BITS);
    localparam int MW  = f_mw(POS_FRAC_BITS);
    localparam int RTW = f_rtw(POS_FRAC_BITS);
    localparam int NW  = f_nw(POS_FRAC_BITS);
    localparam int NP  = 2 * RTW;
    localparam int RMW = RTW + 3;

    logic w_en;

    // Square root pipeline, one root bit per stage.
    logic           r_sv   [0:RTW];
    logic [RMW-1:0] r_rem  [0:RTW];
    logic [RTW-1:0] r_root [0:RTW];
    logic [NP-1:0]  r_n    [0:RTW];
    logic [MW-1:0]  r_sb   [0:RTW];
    logic [AW-1:0]  r_sa   [0:RTW];
    t_ctl           r_sc   [0:RTW];

    // Restoring divider pipeline, one quotient bit per stage.
    logic          r_dv   [0:NW];
    logic [AW-1:0] r_drem [0:NW];
    logic [NW-1:0] r_dnq  [0:NW];
    logic [AW-1:0] r_da   [0:NW];
    t_ctl          r_dc   [0:NW];

    logic               r_ov;
    logic               r_hit;
    logic signed [31:0] r_time;

    logic        w_hit;
    logic [31:0] w_time;
    logic [NW-1:0] w_q, w_qneg;
    t_ctl        w_ctl;

    assign w_en       = !r_ov || !i_stall;
    assign o_pop      = w_en && i_q_valid;
    assign o_valid    = r_ov;
    assign o_hit      = r_hit;
    assign o_hit_time = r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_n[0]    <= NP'(i_d) << (2 * S);
            r_sb[0]   <= i_babs;
            r_sa[0]   <= i_a;
            r_sc[0]   <= i_ctl;
        end
    end

    for (genvar k = 1; k <= RTW; k++) begin : g_sqrt
        logic [RMW-1:0] w_t;
        logic [RMW-1:0] w_trial;
        logic           w_ge;

        assign w_t     = {r_rem[k-1][RMW-3:0], r_n[k-1][NP-1 -: 2]};
        assign w_trial = {1'b0, r_root[k-1], 2'b01};
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (w_en) begin
                r_sv[k] <= r_sv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k]  <= w_ge ? (w_t - w_trial) : w_t;
                r_root[k] <= {r_root[k-1][RTW-2:0], w_ge};
                r_n[k]    <= {r_n[k-1][NP-3:0], 2'b00};
                r_sb[k]   <= r_sb[k-1];
                r_sa[k]   <= r_sa[k-1];
                r_sc[k]   <= r_sc[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= r_sv[RTW];
        end
    end

    // Numerator |B| * 2^s - floor(sqrt(D * 2^(2s))), never negative for solve items.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_drem[0] <= '0;
            r_dnq[0]  <= (NW'(r_sb[RTW]) << S) - NW'(r_root[RTW]);
            r_da[0]   <= r_sa[RTW];
            r_dc[0]   <= r_sc[RTW];
        end
    end

    for (genvar k = 1; k <= NW; k++) begin : g_div
        logic [AW:0] w_t;
        logic        w_ge;

        assign w_t  = {r_drem[k-1], r_dnq[k-1][NW-1]};
        assign w_ge = (w_t >= {1'b0, r_da[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (w_en) begin
                r_dv[k] <= r_dv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_drem[k] <= w_ge ? AW'(w_t - {1'b0, r_da[k-1]}) : AW'(w_t);
                r_dnq[k]  <= {r_dnq[k-1][NW-2:0], w_ge};
                r_da[k]   <= r_da[k-1];
                r_dc[k]   <= r_dc[k-1];
            end
        end
    end

    always_comb begin
        w_ctl  = r_dc[NW];
        w_q    = r_dnq[NW];
        w_qneg = (w_q > NW'(TIME_NEG_MAG)) ? NW'(TIME_NEG_MAG) : w_q;
        w_hit  = 1'b0;
        w_time = '0;
        case (w_ctl.kind)
            KIND_ZERO: begin
                w_hit = 1'b1;
            end
            KIND_SOLVE: begin
                w_hit = 1'b1;
                if (w_ctl.b_neg) begin
                    w_time = (w_q > NW'(TIME_POS_MAX)) ? TIME_POS_MAX : w_q[31:0];
                end else begin
                    w_time = 32'd0 - w_qneg[31:0];
                end
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_dv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit  <= w_hit;
            r_time <= signed'(w_time);
        end
    end

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_hit) |-> (r_time == '0))
        else $error("miss reported with a nonzero time");

endmodule

// ===== src/moving_circle_collision_time_top.sv =====
// Collision time of two circles moving in straight lines. Each item carries
// two positions (signed, POS_FRAC_BITS fraction bits) and two velocities
// (signed Q7.8); the block answers every item with exactly one result: a hit
// flag and the signed Q15.16 time at which the centers are collision_radius
// apart, saturated to the 32-bit range and zero on a miss. When the bodies
// already overlap, a hit reports time zero; bodies that are apart and do not
// move relative to each other miss. The sustained rate is one item per clock
// while the output is not stalled. The square root and the divider produce
// one bit per pipeline stage; RTW and NW, the root and quotient widths, are 57
// and 57 at the default of eight fraction bits. A front pipeline forms the
// quadratic and its discriminant and sorts each item into miss, hit at zero,
// or solve; a four-entry queue then hands it to the back pipeline that takes
// the root and the quotient. Either side may stall without stopping the other
// until the queue fills. The radius register (byte address 0, reset 1.0)
// should be written only while no item is in flight.
module moving_circle_collision_time_top import mcct_pkg::*; #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [23:0]   i_first_pos_x,
    input  logic signed [23:0]   i_first_pos_y,
    input  logic signed [23:0]   i_second_pos_x,
    input  logic signed [23:0]   i_second_pos_y,
    input  logic signed [15:0]   i_first_vel_x,
    input  logic signed [15:0]   i_first_vel_y,
    input  logic signed [15:0]   i_second_vel_x,
    input  logic signed [15:0]   i_second_vel_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic signed [31:0]   o_hit_time
);

    localparam int MW = f_mw(POS_FRAC_BITS);
    localparam int DW = f_dw(POS_FRAC_BITS);
    localparam int QW = $bits(t_ctl) + MW + AW + DW;

    logic [15:0] r_radius;

    logic          w_push, w_pop, w_q_full, w_q_empty;
    t_ctl          w_f_ctl, w_q_ctl;
    logic [MW-1:0] w_f_babs, w_q_babs;
    logic [AW-1:0] w_f_a, w_q_a;
    logic [DW-1:0] w_f_d, w_q_d;
    logic [QW-1:0] w_q_in, w_q_out;

    // The register port never waits. Addresses above the radius read as zero
    // and ignore writes.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == IDX_RADIUS) ? {16'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == IDX_RADIUS) begin
            r_radius <= pwdata[15:0];
        end
    end

    mcct_front #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_pos_x  (i_first_pos_x),
        .i_first_pos_y  (i_first_pos_y),
        .i_second_pos_x (i_second_pos_x),
        .i_second_pos_y (i_second_pos_y),
        .i_first_vel_x  (i_first_vel_x),
        .i_first_vel_y  (i_first_vel_y),
        .i_second_vel_x (i_second_vel_x),
        .i_second_vel_y (i_second_vel_y),
        .i_radius       (r_radius),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_ctl          (w_f_ctl),
        .o_babs         (w_f_babs),
        .o_a            (w_f_a),
        .o_d            (w_f_d)
    );

    // Each queued item carries its class, |B|, A and the discriminant.
    assign w_q_in = {w_f_ctl, w_f_babs, w_f_a, w_f_d};
    assign {w_q_ctl, w_q_babs, w_q_a, w_q_d} = w_q_out;

    mcct_fifo #(
        .W     (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    mcct_back #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (!w_q_empty),
        .i_ctl      (w_q_ctl),
        .i_babs     (w_q_babs),
        .i_a        (w_q_a),
        .i_d        (w_q_d),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_hit      (o_hit),
        .o_hit_time (o_hit_time)
    );

endmodule
